// ===== rtl/lbs_pkg.sv =====
// Shared types and constants for the linear blend skinning unit.
`default_nettype none

package lbs_pkg;

    // Command codes of an input item
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_INFL = 1'b1;

    // Palette geometry: three stored rows of four elements per joint
    localparam int         ROWS         = 3;
    localparam logic [3:0] ELEM_COUNT   = 4'd12;
    localparam int         PAL_CALC_W   = 10;
    localparam logic [1:0] LAST_ROW     = 2'd2;

    // Weight format, unsigned Q1.16 with one at 2^16
    localparam int          WEIGHT_BITS = 16;
    localparam logic [16:0] WEIGHT_ONE  = 17'h10000;

    // Accumulator format and clamp limits
    localparam int ACC_W = 48;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

    // One palette row: element 0 in lane 0
    typedef logic [3:0][31:0] row_data_t;

    // Tag that travels with one row through the datapath
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       sat;
    } row_tag_t;

endpackage

`default_nettype wire

// ===== rtl/lbs_in_if.sv =====
// Input channel: palette loads and skinning influences.
`default_nettype none

interface lbs_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [5:0]         palette_entry;
    logic [3:0]         matrix_element;
    logic signed [31:0] element_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [5:0]         joint_index;
    logic [16:0]        skin_weight;
    logic               last_influence;

    modport source (
        output valid, cmd, palette_entry, matrix_element, element_value,
               pos_x, pos_y, pos_z, joint_index, skin_weight, last_influence,
        input  ready
    );

    modport sink (
        input  valid, cmd, palette_entry, matrix_element, element_value,
               pos_x, pos_y, pos_z, joint_index, skin_weight, last_influence,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/lbs_out_if.sv =====
// Output channel: skinned vertex positions.
`default_nettype none

interface lbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;

    modport source (
        output valid, out_x, out_y, out_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/lbs_palette.sv =====
// Joint palette memory: one row per address, per-lane write, registered read.
`default_nettype none

module lbs_palette
    import lbs_pkg::*;
#(
    parameter int DEPTH  = 192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [1:0]        wr_lane,
    input  wire logic [31:0]       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output row_data_t              rd_data
);

    row_data_t mem [DEPTH];
    row_data_t rd_data_reg;

    // Write one element of a row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_lane] <= wr_data;
        end
    end

    // Read a whole row into the read register
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/lbs_row_dp.sv =====
// Row datapath: dot product with the vertex, clamp, and weight multiply.
`default_nettype none

module lbs_row_dp
    import lbs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire row_tag_t           issue,
    input  wire row_data_t          rd_data,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic [16:0]        weight,
    output row_tag_t                res_tag,
    output logic signed [65:0]      res_tw,
    output logic                    busy
);

    row_tag_t tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg;
    row_tag_t tag_c_next;

    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [63:0] p0_next, p1_next, p2_next;
    logic signed [31:0] m3_reg;
    logic signed [ACC_W-1:0] t_reg, t_next;
    logic signed [65:0] tw_reg, tw_next;

    logic signed [65:0] dot_sum;
    logic signed [66:0] t_raw;
    logic signed [17:0] weight_s;

    // Stage A: three element products against the vertex
    always_comb
    begin
        p0_next = 64'($signed(rd_data[0])) * 64'(pos_x);
        p1_next = 64'($signed(rd_data[1])) * 64'(pos_y);
        p2_next = 64'($signed(rd_data[2])) * 64'(pos_z);
    end

    // Stage B: floor of the scaled sum plus translation, clamp to accumulator range
    always_comb
    begin
        dot_sum    = 66'(p0_reg) + 66'(p1_reg) + 66'(p2_reg);
        t_raw      = 67'(dot_sum >>> FRAC_BITS) + 67'(m3_reg);
        tag_c_next = tag_b_reg;
        if (t_raw > 67'(ACC_MAX))
        begin
            t_next         = ACC_MAX;
            tag_c_next.sat = 1'b1;
        end
        else if (t_raw < 67'(ACC_MIN))
        begin
            t_next         = ACC_MIN;
            tag_c_next.sat = 1'b1;
        end
        else
        begin
            t_next = ACC_W'(t_raw);
        end
    end

    // Stage C: scale by the weight
    assign weight_s = $signed({1'b0, weight});
    assign tw_next  = 66'(t_reg) * 66'(weight_s);

    // Advance tags and data through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            p0_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            m3_reg    <= '0;
            t_reg     <= '0;
            tw_reg    <= '0;
        end
        else
        begin
            tag_a_reg <= issue;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_c_next;
            tag_d_reg <= tag_c_reg;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            m3_reg    <= $signed(rd_data[3]);
            t_reg     <= t_next;
            tw_reg    <= tw_next;
        end
    end

    assign res_tag = tag_d_reg;
    assign res_tw  = tw_reg;
    assign busy    = tag_a_reg.valid | tag_b_reg.valid | tag_c_reg.valid | tag_d_reg.valid;

endmodule

`default_nettype wire

// ===== rtl/linear_blend_skinning.sv =====
// Top level of the linear blend skinning unit: sequencer, accumulators, output register.
// Flow: a load is written into the palette when it is taken; an influence moves from idle to the
// issue state, where its three rows are read from the palette memory (skipped for a joint out of
// range), then to the drain state, which waits until the row datapath has written back its rows.
// After a last influence the finish state fills the output register once no older result waits.
// Reset: accumulators and saturation flag clear; palette contents stay undefined.
`default_nettype none

module linear_blend_skinning
    import lbs_pkg::*;
#(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lbs_in_if.sink    item,
    lbs_out_if.source result
);

    localparam int PAL_DEPTH = MAX_JOINTS * ROWS;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic [1:0]         row_cnt_reg, row_cnt_next;
    logic [5:0]         joint_reg, joint_next;
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [31:0] pos_z_reg, pos_z_next;
    logic [16:0]        weight_reg, weight_next;
    logic               last_reg, last_next;
    logic signed [ACC_W-1:0] acc_reg [ROWS];
    logic signed [ACC_W-1:0] acc_next [ROWS];
    logic               sticky_reg, sticky_next;
    logic signed [31:0] out_x_reg, out_x_next;
    logic signed [31:0] out_y_reg, out_y_next;
    logic signed [31:0] out_z_reg, out_z_next;
    logic               out_sat_reg, out_sat_next;
    logic               out_valid_reg, out_valid_next;

    row_tag_t           issue;
    row_tag_t           dp_tag;
    logic signed [65:0] dp_tw;
    logic               dp_busy;
    row_data_t          rd_data;

    logic                  pal_we;
    logic [PAL_CALC_W-1:0] ld_calc;
    logic [PAL_CALC_W-1:0] rd_calc;
    logic                  fin_go;

    logic signed [49:0]      contrib;
    logic signed [50:0]      acc_sum;
    logic signed [ACC_W-1:0] acc_upd;
    logic                    acc_clamp;
    logic signed [31:0]      out_val [ROWS];
    logic [ROWS-1:0]         out_clamp;

    assign item.ready = (state_reg == ST_IDLE);

    // Palette write on a load transfer that is in range
    assign pal_we = item.valid && item.ready && (item.cmd == CMD_LOAD)
                    && (int'(item.palette_entry) < MAX_JOINTS)
                    && (item.matrix_element < ELEM_COUNT);
    assign ld_calc = (PAL_CALC_W'(item.palette_entry) << 1) + PAL_CALC_W'(item.palette_entry)
                     + PAL_CALC_W'(item.matrix_element[3:2]);
    assign rd_calc = (PAL_CALC_W'(joint_reg) << 1) + PAL_CALC_W'(joint_reg)
                     + PAL_CALC_W'(row_cnt_reg);

    lbs_palette #(
        .DEPTH  (PAL_DEPTH),
        .ADDR_W (PAL_AW)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (ld_calc[PAL_AW-1:0]),
        .wr_lane (item.matrix_element[1:0]),
        .wr_data (item.element_value),
        .rd_en   (issue.valid),
        .rd_addr (rd_calc[PAL_AW-1:0]),
        .rd_data (rd_data)
    );

    lbs_row_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_row_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .rd_data (rd_data),
        .pos_x   (pos_x_reg),
        .pos_y   (pos_y_reg),
        .pos_z   (pos_z_reg),
        .weight  (weight_reg),
        .res_tag (dp_tag),
        .res_tw  (dp_tw),
        .busy    (dp_busy)
    );

    // Weighted contribution into its accumulator, clamped
    always_comb
    begin
        contrib   = 50'(dp_tw >>> WEIGHT_BITS);
        acc_sum   = 51'(acc_reg[dp_tag.row]) + 51'(contrib);
        acc_clamp = 1'b0;
        if (acc_sum > 51'(ACC_MAX))
        begin
            acc_upd   = ACC_MAX;
            acc_clamp = 1'b1;
        end
        else if (acc_sum < 51'(ACC_MIN))
        begin
            acc_upd   = ACC_MIN;
            acc_clamp = 1'b1;
        end
        else
        begin
            acc_upd = ACC_W'(acc_sum);
        end
    end

    // Clamp each accumulator to the output range
    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            out_clamp[i] = 1'b0;
            if (acc_reg[i] > ACC_W'(OUT_MAX))
            begin
                out_val[i]   = OUT_MAX;
                out_clamp[i] = 1'b1;
            end
            else if (acc_reg[i] < ACC_W'(OUT_MIN))
            begin
                out_val[i]   = OUT_MIN;
                out_clamp[i] = 1'b1;
            end
            else
            begin
                out_val[i] = 32'(acc_reg[i]);
            end
        end
    end

    assign fin_go = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        joint_next     = joint_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        sticky_next    = sticky_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_z_next     = out_z_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_valid_reg;
        issue          = '0;

        // Drop the result once it is transferred
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Write back a finished row
        if (dp_tag.valid)
        begin
            acc_next[dp_tag.row] = acc_upd;
            sticky_next          = sticky_reg | dp_tag.sat | acc_clamp;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item.valid && (item.cmd == CMD_INFL))
                begin
                    joint_next   = item.joint_index;
                    pos_x_next   = item.pos_x;
                    pos_y_next   = item.pos_y;
                    pos_z_next   = item.pos_z;
                    weight_next  = (item.skin_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                                   : item.skin_weight;
                    last_next    = item.last_influence;
                    row_cnt_next = '0;
                    if (int'(item.joint_index) < MAX_JOINTS)
                    begin
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_ISSUE:
            begin
                issue.valid = 1'b1;
                issue.row   = row_cnt_reg;
                if (row_cnt_reg == LAST_ROW)
                begin
                    row_cnt_next = '0;
                    state_next   = ST_DRAIN;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 2'd1;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_busy)
                begin
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (fin_go)
                begin
                    out_x_next     = out_val[0];
                    out_y_next     = out_val[1];
                    out_z_next     = out_val[2];
                    out_sat_next   = sticky_reg | (|out_clamp);
                    out_valid_next = 1'b1;
                    for (int i = 0; i < ROWS; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    sticky_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, accumulators and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            joint_reg     <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            weight_reg    <= '0;
            last_reg      <= 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                acc_reg[i] <= '0;
            end
            sticky_reg    <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            joint_reg     <= joint_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            weight_reg    <= weight_next;
            last_reg      <= last_next;
            acc_reg       <= acc_next;
            sticky_reg    <= sticky_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_z_reg     <= out_z_next;
            out_sat_reg   <= out_sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_x     = out_x_reg;
    assign result.out_y     = out_y_reg;
    assign result.out_z     = out_z_reg;
    assign result.saturated = out_sat_reg;

    // No new item while rows are still in flight
    a_ready_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !dp_busy)
        else $error("input taken while row datapath busy");

    // Row write-backs only while an influence is being worked on
    a_wb_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        dp_tag.valid |-> (state_reg == ST_ISSUE || state_reg == ST_DRAIN))
        else $error("row write-back outside influence work");

    // Emitting a vertex leaves clear accumulators and a valid result
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (out_valid_reg && acc_reg[0] == '0 && acc_reg[1] == '0
                    && acc_reg[2] == '0 && !sticky_reg))
        else $error("accumulators not cleared after vertex emit");

    // Row issue follows the row counter order
    a_issue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.row != LAST_ROW)
        |=> (issue.valid && issue.row == $past(issue.row) + 2'd1))
        else $error("row issue out of order");

endmodule

`default_nettype wire
